[design/gfpc_pkg.sv]
package gfpc_pkg;

  localparam int SampleBitsDef = 16;
  localparam int SampleW       = 16;
  localparam int CountW        = 16;
  localparam int CreditW       = 8;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 16;

  localparam logic [CountW-1:0] BottleLimit = 16'd700;
  localparam logic [CountW-1:0] CountMax    = '1;

  localparam logic [CfgIdxW-1:0] CfgLowLevel   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgClearLevel = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLeakLevel  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTarget     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCoolantMin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPulseTicks = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPulseMax   = 3'd6;

  localparam logic [CountW-1:0]  PulseTicksRst = 16'd500;
  localparam logic [CreditW-1:0] PulseMaxRst   = 8'd10;

  typedef enum logic [1:0] {
    OpTick      = 2'd0,
    OpLowOvr    = 2'd1,
    OpLimitOvr  = 2'd2,
    OpLoadBottle = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModePumping = 2'd1,
    ModePause   = 2'd2,
    ModeLockout = 2'd3
  } mode_e;

  typedef struct packed {
    op_e                op;
    logic [SampleW-1:0] pressure;
    logic [SampleW-1:0] coolant_temp;
    logic [CountW-1:0]  bottle_value;
  } gfpc_in_t;

  typedef struct packed {
    logic               relay_closed;
    logic               pressure_fault;
    mode_e              mode;
    logic [CountW-1:0]  pulses_done;
    logic [CountW-1:0]  bottle_left;
    logic [CreditW-1:0] override_credits;
  } gfpc_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } gfpc_cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] low_level;
    logic [SampleW-1:0] clear_level;
    logic [SampleW-1:0] leak_level;
    logic [SampleW-1:0] target;
    logic [SampleW-1:0] coolant_min;
    logic [CountW-1:0]  pulse_ticks;
    logic [CreditW-1:0] pulse_max;
  } gfpc_regs_t;

  typedef struct packed {
    mode_e              mode;
    logic [CountW-1:0]  ticks;
    logic               fault;
    logic               relay;
    logic [CountW-1:0]  pulses;
    logic [CountW-1:0]  bottles;
    logic [CreditW-1:0] credits;
    logic               limit_ovr;
  } gfpc_state_t;

endpackage

[design/gfpc_chan_if.sv]
interface gfpc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/gfpc_cfg_regs.sv]
module gfpc_cfg_regs
  import gfpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gfpc_chan_if.sink  cfg_i,
  output gfpc_regs_t regs_o
);

  gfpc_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CfgLowLevel:   regs_d.low_level   = cfg_i.data.wdata;
        CfgClearLevel: regs_d.clear_level = cfg_i.data.wdata;
        CfgLeakLevel:  regs_d.leak_level  = cfg_i.data.wdata;
        CfgTarget:     regs_d.target      = cfg_i.data.wdata;
        CfgCoolantMin: regs_d.coolant_min = cfg_i.data.wdata;
        CfgPulseTicks: regs_d.pulse_ticks = cfg_i.data.wdata;
        CfgPulseMax:   regs_d.pulse_max   = cfg_i.data.wdata[CreditW-1:0];
        default:       regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.low_level   <= '0;
      regs_q.clear_level <= '0;
      regs_q.leak_level  <= '0;
      regs_q.target      <= '0;
      regs_q.coolant_min <= '0;
      regs_q.pulse_ticks <= PulseTicksRst;
      regs_q.pulse_max   <= PulseMaxRst;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

[design/gfpc_step.sv]
module gfpc_step
  import gfpc_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  gfpc_in_t    item_i,
  input  gfpc_regs_t  regs_i,
  input  gfpc_state_t state_i,
  output gfpc_state_t state_o
);

  localparam int SmplW = (SampleBits < SampleW) ? SampleBits : SampleW;

  logic [SampleW-1:0] p, t;
  logic               warm;
  logic [CountW-1:0]  ticks_inc;
  logic [CountW-1:0]  pulses_inc;

  assign p          = SampleW'(item_i.pressure[SmplW-1:0]);
  assign t          = SampleW'(item_i.coolant_temp[SmplW-1:0]);
  assign warm       = t >= regs_i.coolant_min;
  assign ticks_inc  = (state_i.ticks == CountMax) ? CountMax : state_i.ticks + 1'b1;
  assign pulses_inc = (state_i.pulses == CountMax) ? CountMax : state_i.pulses + 1'b1;

  always_comb begin
    state_o = state_i;
    case (item_i.op)
      OpTick: begin
        if (warm) begin
          if (p < regs_i.low_level) begin
            state_o.fault = 1'b1;
          end else if (p >= regs_i.clear_level) begin
            state_o.fault = 1'b0;
          end
        end
        case (state_i.mode)
          ModeIdle: begin
            state_o.relay = 1'b0;
            if (warm) begin
              if (p < regs_i.clear_level &&
                  (p > regs_i.leak_level || state_i.credits != '0)) begin
                state_o.mode = ModePumping;
              end else begin
                state_o.ticks = '0;
              end
            end
          end
          ModePumping: begin
            state_o.relay = 1'b1;
            state_o.ticks = ticks_inc;
            if (ticks_inc >= regs_i.pulse_ticks) begin
              state_o.mode   = ModePause;
              state_o.ticks  = '0;
              state_o.pulses = pulses_inc;
              if (state_i.bottles != '0 && state_i.bottles < BottleLimit) begin
                state_o.bottles = state_i.bottles - 1'b1;
              end else begin
                state_o.bottles = '0;
              end
              if (state_i.credits != '0) begin
                state_o.credits = state_i.credits - 1'b1;
              end
            end
          end
          ModePause: begin
            state_o.relay = 1'b0;
            state_o.ticks = ticks_inc;
            if (state_i.pulses >= CountW'(regs_i.pulse_max)) begin
              state_o.mode = (p >= regs_i.clear_level) ? ModeIdle : ModeLockout;
            end else if (p >= regs_i.target) begin
              state_o.mode = ModeIdle;
            end else if (ticks_inc > regs_i.pulse_ticks) begin
              state_o.ticks = '0;
              state_o.mode  = (p < regs_i.leak_level) ? ModeIdle : ModePumping;
            end
          end
          default: begin
            state_o.relay = 1'b0;
            if (state_i.limit_ovr) begin
              state_o.mode      = ModeIdle;
              state_o.pulses    = '0;
              state_o.limit_ovr = 1'b0;
            end
          end
        endcase
      end
      OpLowOvr: begin
        state_o.credits = regs_i.pulse_max;
        state_o.pulses  = '0;
      end
      OpLimitOvr: begin
        state_o.limit_ovr = 1'b1;
      end
      default: begin
        state_o.bottles = item_i.bottle_value;
      end
    endcase
  end

endmodule

[design/gas_fill_pulse_controller_unit.sv]
// Channel  Dir  Payload                                             Accept
// in_i     in   op, pressure, coolant_temp, bottle_value            valid & ready
// out_o    out  relay_closed, pressure_fault, mode, pulses_done,    valid & ready
//               bottle_left, override_credits
// cfg_i    in   index, wdata                                        valid & ready
//
// One beat per cycle sustained while out_o.ready is high; each result is held
// in the result register. The input register feeds the combinational control
// step, which loads the state and the result register together.
// Reset puts the configuration registers at their defaults and clears all state.
// in_i.ready drops only while both the input and result registers are full and
// out_o.ready is low. cfg_i is always ready.
module gas_fill_pulse_controller_unit
  import gfpc_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfpc_chan_if.sink   in_i,
  gfpc_chan_if.source out_o,
  gfpc_chan_if.sink   cfg_i
);

  gfpc_regs_t  regs;
  gfpc_in_t    item_q;
  logic        item_vld_q;
  gfpc_state_t state_q, state_d;
  gfpc_out_t   res_q, res_d;
  logic        res_vld_q;
  logic        advance;

  gfpc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  gfpc_step #(
    .SampleBits (SampleBits)
  ) u_step (
    .item_i  (item_q),
    .regs_i  (regs),
    .state_i (state_q),
    .state_o (state_d)
  );

  assign advance    = !res_vld_q || out_o.ready;
  assign in_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.data;
    end
  end

  always_comb begin
    res_d.relay_closed     = state_d.relay;
    res_d.pressure_fault   = state_d.fault;
    res_d.mode             = state_d.mode;
    res_d.pulses_done      = state_d.pulses;
    res_d.bottle_left      = state_d.bottles;
    res_d.override_credits = state_d.credits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '{mode: ModeIdle, default: '0};
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
      if (item_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

`ifndef SYNTHESIS
  a_state_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(item_vld_q && advance) |=> $stable(state_q))
    else $error("state changed without a step");

  a_item_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !advance) |=> (item_vld_q && $stable(item_q)))
    else $error("input register lost a stalled beat");

  a_relay_open_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == ModeIdle || state_q.mode == ModeLockout) |-> !state_q.relay)
    else $error("relay closed in idle or lockout");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && advance) |=> (res_vld_q && res_q.mode == state_q.mode &&
                                 res_q.pulses_done == state_q.pulses))
    else $error("result register out of step with state");
`endif

endmodule
